FILE: rtl/rrpc_pkg.sv
package rrpc_pkg;

  localparam int RADIUS_BITS = 10;
  localparam int COLOR_BITS  = 4;
  localparam int PAIR_BITS   = 8;
  localparam int DATA_BITS   = 32;
  localparam int ADDR_BITS   = 5;
  localparam int IDX_BITS    = 3;

  typedef enum logic [1:0] {
    REGION_SKIP     = 2'd0,
    REGION_BORDER   = 2'd1,
    REGION_INTERIOR = 2'd2
  } region_t;

  typedef enum logic [IDX_BITS-1:0] {
    REG_LEFT   = 3'd0,
    REG_TOP    = 3'd1,
    REG_RIGHT  = 3'd2,
    REG_BOTTOM = 3'd3,
    REG_RADIUS = 3'd4,
    REG_BORDER = 3'd5,
    REG_FILL   = 3'd6,
    REG_COLOR  = 3'd7
  } reg_idx_t;

  // geometry verdict carried alongside the corner offsets
  typedef struct packed {
    logic outside;
    logic corner;
    logic edge_border;
  } geom_flags_t;

endpackage

FILE: rtl/rrpc_regs.sv
module rrpc_regs #(
  parameter int COORD_BITS = 11
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [rrpc_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [rrpc_pkg::DATA_BITS-1:0]       pwdata,
  output logic [rrpc_pkg::DATA_BITS-1:0]       prdata,
  output logic                                 pready,
  output logic [COORD_BITS-1:0]                left_o,
  output logic [COORD_BITS-1:0]                top_o,
  output logic [COORD_BITS-1:0]                right_o,
  output logic [COORD_BITS-1:0]                bottom_o,
  output logic [rrpc_pkg::RADIUS_BITS-1:0]     radius_o,
  output logic [rrpc_pkg::RADIUS_BITS-1:0]     border_o,
  output logic                                 fill_o,
  output logic [rrpc_pkg::PAIR_BITS-1:0]       color_o
);

  logic [COORD_BITS-1:0]             left_r, top_r, right_r, bottom_r;
  logic [rrpc_pkg::RADIUS_BITS-1:0]  radius_r, border_r;
  logic                              fill_r;
  logic [rrpc_pkg::PAIR_BITS-1:0]    color_r;
  logic                              wr_en;
  rrpc_pkg::reg_idx_t                idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = rrpc_pkg::reg_idx_t'(paddr[rrpc_pkg::ADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      top_r    <= '0;
      right_r  <= '0;
      bottom_r <= '0;
      radius_r <= '0;
      border_r <= rrpc_pkg::RADIUS_BITS'(1);
      fill_r   <= 1'b0;
      color_r  <= '0;
    end else if (wr_en) begin
      case (idx)
        rrpc_pkg::REG_LEFT:   left_r   <= pwdata[COORD_BITS-1:0];
        rrpc_pkg::REG_TOP:    top_r    <= pwdata[COORD_BITS-1:0];
        rrpc_pkg::REG_RIGHT:  right_r  <= pwdata[COORD_BITS-1:0];
        rrpc_pkg::REG_BOTTOM: bottom_r <= pwdata[COORD_BITS-1:0];
        rrpc_pkg::REG_RADIUS: radius_r <= pwdata[rrpc_pkg::RADIUS_BITS-1:0];
        rrpc_pkg::REG_BORDER: border_r <= pwdata[rrpc_pkg::RADIUS_BITS-1:0];
        rrpc_pkg::REG_FILL:   fill_r   <= pwdata[0];
        rrpc_pkg::REG_COLOR:  color_r  <= pwdata[rrpc_pkg::PAIR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rrpc_pkg::REG_LEFT:   prdata = rrpc_pkg::DATA_BITS'(left_r);
      rrpc_pkg::REG_TOP:    prdata = rrpc_pkg::DATA_BITS'(top_r);
      rrpc_pkg::REG_RIGHT:  prdata = rrpc_pkg::DATA_BITS'(right_r);
      rrpc_pkg::REG_BOTTOM: prdata = rrpc_pkg::DATA_BITS'(bottom_r);
      rrpc_pkg::REG_RADIUS: prdata = rrpc_pkg::DATA_BITS'(radius_r);
      rrpc_pkg::REG_BORDER: prdata = rrpc_pkg::DATA_BITS'(border_r);
      rrpc_pkg::REG_FILL:   prdata = rrpc_pkg::DATA_BITS'(fill_r);
      rrpc_pkg::REG_COLOR:  prdata = rrpc_pkg::DATA_BITS'(color_r);
      default:              prdata = '0;
    endcase
  end

  assign left_o   = left_r;
  assign top_o    = top_r;
  assign right_o  = right_r;
  assign bottom_o = bottom_r;
  assign radius_o = radius_r;
  assign border_o = border_r;
  assign fill_o   = fill_r;
  assign color_o  = color_r;

endmodule

FILE: rtl/rrpc_geom.sv
module rrpc_geom #(
  parameter int COORD_BITS = 11,
  parameter int SW         = 13
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    valid_i,
  input  logic [COORD_BITS-1:0]                   x_i,
  input  logic [COORD_BITS-1:0]                   y_i,
  input  logic [COORD_BITS-1:0]                   left_i,
  input  logic [COORD_BITS-1:0]                   top_i,
  input  logic [COORD_BITS-1:0]                   right_i,
  input  logic [COORD_BITS-1:0]                   bottom_i,
  input  logic [rrpc_pkg::RADIUS_BITS-1:0]        radius_i,
  input  logic [rrpc_pkg::RADIUS_BITS-1:0]        border_i,
  output logic                                    valid_o,
  output logic [COORD_BITS-1:0]                   x_o,
  output logic [COORD_BITS-1:0]                   y_o,
  output rrpc_pkg::geom_flags_t                   flags_o,
  output logic signed [SW-1:0]                    dx_o,
  output logic signed [SW-1:0]                    dy_o,
  output logic signed [rrpc_pkg::RADIUS_BITS:0]   inner_o,
  output logic [rrpc_pkg::RADIUS_BITS-1:0]        radius_o
);

  logic [rrpc_pkg::RADIUS_BITS-1:0]      tw;
  logic signed [SW-1:0]                  xs, ys, ls, ts_e, rs_e, bs, rad, thk;
  logic signed [SW-1:0]                  x1r, x2r, y1r, y2r, x1t, x2t, y1t, y2t;
  logic                                  lc, rc, tc, bc;
  rrpc_pkg::geom_flags_t                 flags_nxt;
  logic signed [SW-1:0]                  dx_nxt, dy_nxt;
  logic signed [rrpc_pkg::RADIUS_BITS:0] inner_nxt;

  logic                                  valid_r;
  logic [COORD_BITS-1:0]                 x_r, y_r;
  rrpc_pkg::geom_flags_t                 flags_r;
  logic signed [SW-1:0]                  dx_r, dy_r;
  logic signed [rrpc_pkg::RADIUS_BITS:0] inner_r;
  logic [rrpc_pkg::RADIUS_BITS-1:0]      radius_r;

  // zero thickness acts as one
  assign tw = (border_i == '0) ? rrpc_pkg::RADIUS_BITS'(1) : border_i;

  assign xs   = SW'(x_i);
  assign ys   = SW'(y_i);
  assign ls   = SW'(left_i);
  assign ts_e = SW'(top_i);
  assign rs_e = SW'(right_i);
  assign bs   = SW'(bottom_i);
  assign rad  = SW'(radius_i);
  assign thk  = SW'(tw);

  assign x1r = ls + rad;
  assign x2r = rs_e - rad;
  assign y1r = ts_e + rad;
  assign y2r = bs - rad;
  assign x1t = ls + thk;
  assign x2t = rs_e - thk;
  assign y1t = ts_e + thk;
  assign y2t = bs - thk;

  assign lc = xs < x1r;
  assign rc = xs > x2r;
  assign tc = ys < y1r;
  assign bc = ys > y2r;

  // corner priority TL, TR, BL, BR reduces to: left arc wins on x, top arc on y
  always_comb begin
    flags_nxt.outside     = (x_i < left_i) || (x_i > right_i) ||
                            (y_i < top_i) || (y_i > bottom_i);
    flags_nxt.corner      = (lc || rc) && (tc || bc);
    flags_nxt.edge_border = (xs < x1t) || (xs > x2t) || (ys < y1t) || (ys > y2t);
    dx_nxt    = lc ? (xs - x1r) : (xs - x2r);
    dy_nxt    = tc ? (ys - y1r) : (ys - y2r);
    inner_nxt = $signed({1'b0, radius_i}) - $signed({1'b0, tw});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    x_r      <= x_i;
    y_r      <= y_i;
    flags_r  <= flags_nxt;
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    inner_r  <= inner_nxt;
    radius_r <= radius_i;
  end

  assign valid_o  = valid_r;
  assign x_o      = x_r;
  assign y_o      = y_r;
  assign flags_o  = flags_r;
  assign dx_o     = dx_r;
  assign dy_o     = dy_r;
  assign inner_o  = inner_r;
  assign radius_o = radius_r;

endmodule

FILE: rtl/rrpc_square.sv
module rrpc_square #(
  parameter int COORD_BITS = 11,
  parameter int SW         = 13
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    valid_i,
  input  logic [COORD_BITS-1:0]                   x_i,
  input  logic [COORD_BITS-1:0]                   y_i,
  input  rrpc_pkg::geom_flags_t                   flags_i,
  input  logic signed [SW-1:0]                    dx_i,
  input  logic signed [SW-1:0]                    dy_i,
  input  logic signed [rrpc_pkg::RADIUS_BITS:0]   inner_i,
  input  logic [rrpc_pkg::RADIUS_BITS-1:0]        radius_i,
  output logic                                    valid_o,
  output logic [COORD_BITS-1:0]                   x_o,
  output logic [COORD_BITS-1:0]                   y_o,
  output rrpc_pkg::geom_flags_t                   flags_o,
  output logic [2*SW-1:0]                         dxsq_o,
  output logic [2*SW-1:0]                         dysq_o,
  output logic [2*rrpc_pkg::RADIUS_BITS-1:0]      rsq_o,
  output logic [2*rrpc_pkg::RADIUS_BITS-1:0]      isq_o
);

  localparam int IW = 2*rrpc_pkg::RADIUS_BITS + 2;

  logic signed [2*SW-1:0]                 pdx, pdy;
  logic signed [IW-1:0]                   pin;
  logic [2*rrpc_pkg::RADIUS_BITS-1:0]     prad;

  logic                                   valid_r;
  logic [COORD_BITS-1:0]                  x_r, y_r;
  rrpc_pkg::geom_flags_t                  flags_r;
  logic [2*SW-1:0]                        dxsq_r, dysq_r;
  logic [2*rrpc_pkg::RADIUS_BITS-1:0]     rsq_r, isq_r;

  assign pdx  = dx_i * dx_i;
  assign pdy  = dy_i * dy_i;
  assign pin  = inner_i * inner_i;
  assign prad = radius_i * radius_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  // |r - t| stays below 2^RADIUS_BITS, so its square fits the low bits
  always_ff @(posedge clk) begin
    x_r     <= x_i;
    y_r     <= y_i;
    flags_r <= flags_i;
    dxsq_r  <= pdx;
    dysq_r  <= pdy;
    rsq_r   <= prad;
    isq_r   <= pin[2*rrpc_pkg::RADIUS_BITS-1:0];
  end

  assign valid_o = valid_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign flags_o = flags_r;
  assign dxsq_o  = dxsq_r;
  assign dysq_o  = dysq_r;
  assign rsq_o   = rsq_r;
  assign isq_o   = isq_r;

endmodule

FILE: rtl/rrpc_class.sv
module rrpc_class #(
  parameter int COORD_BITS = 11,
  parameter int SW         = 13
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    valid_i,
  input  logic [COORD_BITS-1:0]                   x_i,
  input  logic [COORD_BITS-1:0]                   y_i,
  input  rrpc_pkg::geom_flags_t                   flags_i,
  input  logic [2*SW-1:0]                         dxsq_i,
  input  logic [2*SW-1:0]                         dysq_i,
  input  logic [2*rrpc_pkg::RADIUS_BITS-1:0]      rsq_i,
  input  logic [2*rrpc_pkg::RADIUS_BITS-1:0]      isq_i,
  input  logic                                    fill_i,
  input  logic [rrpc_pkg::PAIR_BITS-1:0]          color_i,
  output logic                                    valid_o,
  output logic [COORD_BITS-1:0]                   x_o,
  output logic [COORD_BITS-1:0]                   y_o,
  output logic [1:0]                              region_o,
  output logic                                    we_o,
  output logic [rrpc_pkg::COLOR_BITS-1:0]         color_o
);

  localparam int DW = 2*SW + 1;

  logic [DW-1:0]                      d2;
  rrpc_pkg::region_t                  region_nxt;
  logic                               we_nxt;
  logic [rrpc_pkg::COLOR_BITS-1:0]    color_nxt;

  logic                               valid_r;
  logic [COORD_BITS-1:0]              x_r, y_r;
  rrpc_pkg::region_t                  region_r;
  logic                               we_r;
  logic [rrpc_pkg::COLOR_BITS-1:0]    color_r;

  assign d2 = DW'(dxsq_i) + DW'(dysq_i);

  always_comb begin
    if (flags_i.outside) begin
      region_nxt = rrpc_pkg::REGION_SKIP;
    end else if (flags_i.corner) begin
      if (d2 > DW'(rsq_i)) begin
        region_nxt = rrpc_pkg::REGION_SKIP;
      end else if (d2 >= DW'(isq_i)) begin
        region_nxt = rrpc_pkg::REGION_BORDER;
      end else begin
        region_nxt = rrpc_pkg::REGION_INTERIOR;
      end
    end else if (flags_i.edge_border) begin
      region_nxt = rrpc_pkg::REGION_BORDER;
    end else begin
      region_nxt = rrpc_pkg::REGION_INTERIOR;
    end

    case (region_nxt)
      rrpc_pkg::REGION_BORDER: begin
        we_nxt    = 1'b1;
        color_nxt = color_i[rrpc_pkg::COLOR_BITS-1:0];
      end
      rrpc_pkg::REGION_INTERIOR: begin
        we_nxt    = fill_i;
        color_nxt = color_i[rrpc_pkg::PAIR_BITS-1:rrpc_pkg::COLOR_BITS];
      end
      default: begin
        we_nxt    = 1'b0;
        color_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    x_r      <= x_i;
    y_r      <= y_i;
    region_r <= region_nxt;
    we_r     <= we_nxt;
    color_r  <= color_nxt;
  end

  assign valid_o  = valid_r;
  assign x_o      = x_r;
  assign y_o      = y_r;
  assign region_o = region_r;
  assign we_o     = we_r;
  assign color_o  = color_r;

endmodule

FILE: rtl/rounded_rect_pixel_classifier.sv
// Rounded rectangle pixel classifier.
// Input: pulse start with in_pixel_x/in_pixel_y; a request is taken on a
// clock edge where start is high and busy is low. busy is high during reset
// and until the first clock edge after it, then stays low, so one pixel can be
// taken on every clock.
// Output: when a request has passed the register stages below, out_valid is
// high for one cycle with the pixel coordinates, region (0 skip, 1 border,
// 2 interior), write enable and palette index. There is no back-pressure;
// each result must be captured in the cycle it appears.
// Throughput is one pixel per clock; latency is four register stages:
// input capture, edge/corner compare, squaring multipliers, and the
// distance compare with output register.
// Configuration sits on an APB-style port, one register per 4-byte word;
// pready is tied high. Change registers only with the pipeline empty.
// Synchronous active-low reset empties the pipeline and loads the register
// reset values (border width 1, all others 0).
module rounded_rect_pixel_classifier #(
  parameter int COORD_BITS = 11
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [COORD_BITS-1:0]               in_pixel_x,
  input  logic [COORD_BITS-1:0]               in_pixel_y,
  output logic                                out_valid,
  output logic [COORD_BITS-1:0]               out_x,
  output logic [COORD_BITS-1:0]               out_y,
  output logic [1:0]                          out_region,
  output logic                                out_write_enable,
  output logic [rrpc_pkg::COLOR_BITS-1:0]     out_color_index,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rrpc_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [rrpc_pkg::DATA_BITS-1:0]      pwdata,
  output logic [rrpc_pkg::DATA_BITS-1:0]      prdata,
  output logic                                pready
);

  // signed width holding edge +/- radius and the corner offsets
  localparam int SW = ((COORD_BITS > rrpc_pkg::RADIUS_BITS) ?
                       COORD_BITS : rrpc_pkg::RADIUS_BITS) + 2;

  logic                                  busy_r;
  logic                                  in_valid_r;
  logic [COORD_BITS-1:0]                 in_x_r, in_y_r;

  logic [COORD_BITS-1:0]                 cfg_left, cfg_top, cfg_right, cfg_bottom;
  logic [rrpc_pkg::RADIUS_BITS-1:0]      cfg_radius, cfg_border;
  logic                                  cfg_fill;
  logic [rrpc_pkg::PAIR_BITS-1:0]        cfg_color;

  logic                                  g_valid;
  logic [COORD_BITS-1:0]                 g_x, g_y;
  rrpc_pkg::geom_flags_t                 g_flags;
  logic signed [SW-1:0]                  g_dx, g_dy;
  logic signed [rrpc_pkg::RADIUS_BITS:0] g_inner;
  logic [rrpc_pkg::RADIUS_BITS-1:0]      g_radius;

  logic                                  s_valid;
  logic [COORD_BITS-1:0]                 s_x, s_y;
  rrpc_pkg::geom_flags_t                 s_flags;
  logic [2*SW-1:0]                       s_dxsq, s_dysq;
  logic [2*rrpc_pkg::RADIUS_BITS-1:0]    s_rsq, s_isq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      in_valid_r <= 1'b0;
    end else begin
      busy_r     <= 1'b0;
      in_valid_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    in_x_r <= in_pixel_x;
    in_y_r <= in_pixel_y;
  end

  assign busy = busy_r;

  rrpc_regs #(.COORD_BITS(COORD_BITS)) u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .left_o   (cfg_left),
    .top_o    (cfg_top),
    .right_o  (cfg_right),
    .bottom_o (cfg_bottom),
    .radius_o (cfg_radius),
    .border_o (cfg_border),
    .fill_o   (cfg_fill),
    .color_o  (cfg_color)
  );

  rrpc_geom #(.COORD_BITS(COORD_BITS), .SW(SW)) u_geom (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (in_valid_r),
    .x_i      (in_x_r),
    .y_i      (in_y_r),
    .left_i   (cfg_left),
    .top_i    (cfg_top),
    .right_i  (cfg_right),
    .bottom_i (cfg_bottom),
    .radius_i (cfg_radius),
    .border_i (cfg_border),
    .valid_o  (g_valid),
    .x_o      (g_x),
    .y_o      (g_y),
    .flags_o  (g_flags),
    .dx_o     (g_dx),
    .dy_o     (g_dy),
    .inner_o  (g_inner),
    .radius_o (g_radius)
  );

  rrpc_square #(.COORD_BITS(COORD_BITS), .SW(SW)) u_square (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (g_valid),
    .x_i      (g_x),
    .y_i      (g_y),
    .flags_i  (g_flags),
    .dx_i     (g_dx),
    .dy_i     (g_dy),
    .inner_i  (g_inner),
    .radius_i (g_radius),
    .valid_o  (s_valid),
    .x_o      (s_x),
    .y_o      (s_y),
    .flags_o  (s_flags),
    .dxsq_o   (s_dxsq),
    .dysq_o   (s_dysq),
    .rsq_o    (s_rsq),
    .isq_o    (s_isq)
  );

  rrpc_class #(.COORD_BITS(COORD_BITS), .SW(SW)) u_class (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (s_valid),
    .x_i      (s_x),
    .y_i      (s_y),
    .flags_i  (s_flags),
    .dxsq_i   (s_dxsq),
    .dysq_i   (s_dysq),
    .rsq_i    (s_rsq),
    .isq_i    (s_isq),
    .fill_i   (cfg_fill),
    .color_i  (cfg_color),
    .valid_o  (out_valid),
    .x_o      (out_x),
    .y_o      (out_y),
    .region_o (out_region),
    .we_o     (out_write_enable),
    .color_o  (out_color_index)
  );

  a_req_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("taken request produced no result");

  a_result_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 4))
    else $error("result without a matching request");

  a_coord_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_x == $past(in_pixel_x, 4)) && (out_y == $past(in_pixel_y, 4)))
    else $error("coordinates lost alignment through the pipeline");

  a_skip_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_region == rrpc_pkg::REGION_SKIP)) |->
      (!out_write_enable && (out_color_index == '0)))
    else $error("skipped pixel carries a write or a colour");

endmodule

FILE: tb/sv/tb.sv
module tb;

  localparam int COORD_BITS  = 11;
  localparam int CYCLE_LIMIT = 200000;
  localparam int CHUNKS      = 12;
  localparam int CHUNK_ITEMS = 70;

  typedef struct {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } pixel_t;

  typedef struct {
    logic [COORD_BITS-1:0]           x;
    logic [COORD_BITS-1:0]           y;
    rrpc_pkg::region_t               region;
    logic                            we;
    logic [rrpc_pkg::COLOR_BITS-1:0] color;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [COORD_BITS-1:0] in_pixel_x = '0;
  logic [COORD_BITS-1:0] in_pixel_y = '0;
  logic out_valid;
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  logic [1:0] out_region;
  logic out_write_enable;
  logic [rrpc_pkg::COLOR_BITS-1:0] out_color_index;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [rrpc_pkg::ADDR_BITS-1:0] paddr = '0;
  logic [rrpc_pkg::DATA_BITS-1:0] pwdata = '0;
  logic [rrpc_pkg::DATA_BITS-1:0] prdata;
  logic pready;

  // shadow of the block's registers, reset values
  logic [COORD_BITS-1:0] rect_left = '0;
  logic [COORD_BITS-1:0] rect_top = '0;
  logic [COORD_BITS-1:0] rect_right = '0;
  logic [COORD_BITS-1:0] rect_bottom = '0;
  logic [rrpc_pkg::RADIUS_BITS-1:0] arc_radius = '0;
  logic [rrpc_pkg::RADIUS_BITS-1:0] thickness = 10'd1;
  logic fill_on = 1'b0;
  logic [rrpc_pkg::PAIR_BITS-1:0] palette_pair = '0;

  pixel_t   pixel_queue[$];
  verdict_t expected_verdicts[$];
  int       idle_pct = 17;
  int       mismatches = 0;
  int       cycle_count = 0;

  rounded_rect_pixel_classifier #(.COORD_BITS(COORD_BITS)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pixel_x(in_pixel_x), .in_pixel_y(in_pixel_y),
    .out_valid(out_valid), .out_x(out_x), .out_y(out_y), .out_region(out_region),
    .out_write_enable(out_write_enable), .out_color_index(out_color_index),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic rrpc_pkg::region_t arc_region(longint dx, longint dy,
                                                   longint rad, longint thick);
    longint d2;
    longint inner;
    d2 = dx * dx + dy * dy;
    inner = rad - thick;
    if (d2 > rad * rad) return rrpc_pkg::REGION_SKIP;
    if (d2 >= inner * inner) return rrpc_pkg::REGION_BORDER;
    return rrpc_pkg::REGION_INTERIOR;
  endfunction

  function automatic verdict_t classify(logic [COORD_BITS-1:0] px,
                                        logic [COORD_BITS-1:0] py);
    verdict_t v;
    longint x, y, x1, y1, x2, y2, rad, thick;
    logic lc, rc, tc, bc;
    x = px;
    y = py;
    x1 = rect_left;
    y1 = rect_top;
    x2 = rect_right;
    y2 = rect_bottom;
    rad = arc_radius;
    thick = (thickness == 0) ? 1 : thickness;
    lc = x < x1 + rad;
    rc = x > x2 - rad;
    tc = y < y1 + rad;
    bc = y > y2 - rad;
    v.x = px;
    v.y = py;
    v.we = 1'b0;
    v.color = '0;
    // corners take priority TL, TR, BL, BR
    if (x < x1 || x > x2 || y < y1 || y > y2) v.region = rrpc_pkg::REGION_SKIP;
    else if (lc && tc) v.region = arc_region(x - (x1 + rad), y - (y1 + rad), rad, thick);
    else if (rc && tc) v.region = arc_region(x - (x2 - rad), y - (y1 + rad), rad, thick);
    else if (lc && bc) v.region = arc_region(x - (x1 + rad), y - (y2 - rad), rad, thick);
    else if (rc && bc) v.region = arc_region(x - (x2 - rad), y - (y2 - rad), rad, thick);
    else if (x < x1 + thick || x > x2 - thick || y < y1 + thick || y > y2 - thick)
      v.region = rrpc_pkg::REGION_BORDER;
    else v.region = rrpc_pkg::REGION_INTERIOR;
    if (v.region == rrpc_pkg::REGION_BORDER) begin
      v.we = 1'b1;
      v.color = palette_pair[3:0];
    end else if (v.region == rrpc_pkg::REGION_INTERIOR) begin
      v.we = fill_on;
      v.color = palette_pair[7:4];
    end
    return v;
  endfunction

  // request driver
  always @(negedge clk) begin
    if (!rst_n || pixel_queue.size() == 0 || $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
    end else begin
      start <= 1'b1;
      in_pixel_x <= pixel_queue[0].x;
      in_pixel_y <= pixel_queue[0].y;
    end
  end

  // request capture and result check
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n) begin
      if (start && !busy) begin
        expected_verdicts.push_back(classify(in_pixel_x, in_pixel_y));
        void'(pixel_queue.pop_front());
      end
      if (out_valid) begin
        if (expected_verdicts.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: x=%0d y=%0d region=%0d we=%0b color=%0d",
                     out_x, out_y, out_region, out_write_enable, out_color_index);
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          if (out_x !== want.x || out_y !== want.y || out_region !== want.region ||
              out_write_enable !== want.we || out_color_index !== want.color) begin
            if (mismatches < 10)
              $display({"mismatch: expected x=%0d y=%0d region=%0d we=%0b color=%0d,",
                        " got x=%0d y=%0d region=%0d we=%0b color=%0d"},
                       want.x, want.y, want.region, want.we, want.color,
                       out_x, out_y, out_region, out_write_enable, out_color_index);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(rrpc_pkg::reg_idx_t idx, logic [rrpc_pkg::DATA_BITS-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      rrpc_pkg::REG_LEFT:   rect_left = val[COORD_BITS-1:0];
      rrpc_pkg::REG_TOP:    rect_top = val[COORD_BITS-1:0];
      rrpc_pkg::REG_RIGHT:  rect_right = val[COORD_BITS-1:0];
      rrpc_pkg::REG_BOTTOM: rect_bottom = val[COORD_BITS-1:0];
      rrpc_pkg::REG_RADIUS: arc_radius = val[rrpc_pkg::RADIUS_BITS-1:0];
      rrpc_pkg::REG_BORDER: thickness = val[rrpc_pkg::RADIUS_BITS-1:0];
      rrpc_pkg::REG_FILL:   fill_on = val[0];
      rrpc_pkg::REG_COLOR:  palette_pair = val[rrpc_pkg::PAIR_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_shape(int l, int t, int r, int b, int rad, int bw, int fill, int pair);
    write_reg(rrpc_pkg::REG_LEFT, l);
    write_reg(rrpc_pkg::REG_TOP, t);
    write_reg(rrpc_pkg::REG_RIGHT, r);
    write_reg(rrpc_pkg::REG_BOTTOM, b);
    write_reg(rrpc_pkg::REG_RADIUS, rad);
    write_reg(rrpc_pkg::REG_BORDER, bw);
    write_reg(rrpc_pkg::REG_FILL, fill);
    write_reg(rrpc_pkg::REG_COLOR, pair);
    // queue fills happen on the rising edge, clear of the driver
    @(posedge clk);
  endtask

  task automatic add_pixel(int x, int y);
    pixel_t p;
    p.x = x;
    p.y = y;
    pixel_queue.push_back(p);
  endtask

  task automatic drain;
    while (pixel_queue.size() != 0 || expected_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic random_shape;
    int l, t, r, b, w, h, rad, bw;
    if ($urandom_range(4) == 0) begin
      // anything goes, inverted rectangles included
      set_shape($urandom_range(2047), $urandom_range(2047), $urandom_range(2047),
                $urandom_range(2047), $urandom_range(1023), $urandom_range(1023),
                $urandom_range(1), $urandom_range(255));
    end else begin
      l = $urandom_range(2047);
      t = $urandom_range(2047);
      w = ($urandom_range(7) == 0) ? $urandom_range(2047) : $urandom_range(80);
      h = ($urandom_range(7) == 0) ? $urandom_range(2047) : $urandom_range(80);
      r = (l + w > 2047) ? 2047 : l + w;
      b = (t + h > 2047) ? 2047 : t + h;
      rad = $urandom_range(((r - l) < (b - t) ? (r - l) : (b - t)) / 2 + 2);
      if (rad > 1023) rad = 1023;
      bw = $urandom_range(rad + 3);
      if (bw > 1023) bw = 1023;
      set_shape(l, t, r, b, rad, bw, $urandom_range(1), $urandom_range(255));
    end
  endtask

  task automatic random_pixel;
    int lo_x, hi_x, lo_y, hi_y;
    if ($urandom_range(9) < 8 && rect_left <= rect_right && rect_top <= rect_bottom) begin
      lo_x = (rect_left < 3) ? 0 : int'(rect_left) - 3;
      hi_x = (rect_right > 2044) ? 2047 : int'(rect_right) + 3;
      lo_y = (rect_top < 3) ? 0 : int'(rect_top) - 3;
      hi_y = (rect_bottom > 2044) ? 2047 : int'(rect_bottom) + 3;
      add_pixel($urandom_range(hi_x, lo_x), $urandom_range(hi_y, lo_y));
    end else begin
      add_pixel($urandom_range(2047), $urandom_range(2047));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset shape: a single pixel at the origin
    add_pixel(0, 0);
    add_pixel(1, 1);
    add_pixel(2047, 2047);
    add_pixel(0, 2047);
    drain();

    // zero thickness acts as one; fill on
    set_shape(100, 50, 300, 200, 20, 0, 1, 8'hA5);
    add_pixel(100, 50);   // skipped, top-left corner
    add_pixel(120, 50);   // on the arc
    add_pixel(120, 70);   // arc centre
    add_pixel(300, 200);  // skipped, bottom-right corner
    add_pixel(280, 200);
    add_pixel(200, 50);
    add_pixel(200, 125);
    add_pixel(99, 125);
    add_pixel(301, 125);
    add_pixel(100, 125);
    add_pixel(300, 125);
    add_pixel(200, 200);
    add_pixel(200, 51);
    drain();

    // full frame, largest radius and border, fill off
    set_shape(0, 0, 2047, 2047, 1023, 1023, 0, 8'hF0);
    add_pixel(0, 0);
    add_pixel(1022, 1022);
    add_pixel(1024, 1024);
    drain();

    // left beyond right: nothing is inside
    set_shape(2047, 0, 0, 2047, 0, 2, 1, 8'h3C);
    add_pixel(1000, 1000);
    add_pixel(0, 0);
    drain();

    for (int c = 0; c < CHUNKS; c++) begin
      idle_pct = (c < CHUNKS / 3) ? 17 : (c < 2 * CHUNKS / 3) ? 54 : 0;
      random_shape();
      for (int i = 0; i < CHUNK_ITEMS; i++) random_pixel();
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
